// File: rtl/cts_pkg.sv
// Shared types and constants for the counter-to-UTC time estimator.
// Used by every module in rtl/; depends on nothing else.
`timescale 1ns / 1ps
package cts_pkg;

  localparam int RingDepthDef  = 16;
  localparam int WindowMaxDef  = 12;
  localparam int PeriodShift   = 22;
  localparam int DivSteps      = 64;
  localparam logic [63:0] InitPeriodRst = 64'd4503599627;
  localparam logic [63:0] DtLimit       = 64'h0000_0100_0000_0000;

  typedef enum logic [0:0] {
    CFG_COUNTER_SHIFT  = 1'b0,
    CFG_INITIAL_PERIOD = 1'b1
  } cfg_idx_t;

  typedef enum logic [0:0] {
    REQ_UPDATE = 1'b0,
    REQ_QUERY  = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    ST_TIME    = 3'd0,
    ST_IGNORED = 3'd1,
    ST_SYNC    = 3'd2,
    ST_PERIOD  = 3'd3,
    ST_RESYNC  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_WRITE, S_READ, S_CMP, S_CHK, S_DIV, S_FIN,
    S_QPREP, S_QM0, S_QM1, S_QM2, S_QM3, S_QRES, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    MUL_LL, MUL_LH, MUL_HL
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD_HI
  } acc_op_t;

  typedef struct packed {
    logic     load_in;
    logic     ring_write;
    logic     ref_read;
    logic     cmp_load;
    logic     sync_start;
    logic     resync;
    logic     div_start;
    logic     period_fin;
    logic     q_prep;
    logic     mul_en;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     q_res;
    logic     res_set;
    status_t  status;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic ignore;
    logic ref_is_cur;
    logic reject;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/cts_div.sv
// Restoring divider, one quotient bit per cycle: 64-bit dividend, 32-bit divisor.
// Depends on cts_pkg.
`timescale 1ns / 1ps
module cts_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic [63:0] quo_r, quo_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [6:0]  cnt_r;
  logic        busy_r, done_r;
  logic [32:0] rem_sh, rem_sub;
  logic        ge;

  always_comb begin
    rem_sh  = {rem_r, quo_r[63]};
    rem_sub = rem_sh - {1'b0, divisor};
    ge      = rem_sh >= {1'b0, divisor};
    rem_nxt = ge ? rem_sub[31:0] : rem_sh[31:0];
    quo_nxt = {quo_r[62:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'(cts_pkg::DivSteps - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: rtl/cts_dp.sv
// Datapath: input latch, midpoint ring, offsets, period, divider, shared
// 32x32 multiplier, configuration registers and output register.
// Depends on cts_pkg and cts_div.
`timescale 1ns / 1ps
module cts_dp #(
  parameter int RING_DEPTH = cts_pkg::RingDepthDef,
  parameter int WINDOW_MAX = cts_pkg::WindowMaxDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cts_pkg::cmd_t        cmd,
  output cts_pkg::sts_t        sts,
  input  logic                 in_req_type,
  input  logic [63:0]          in_local_send,
  input  logic signed [63:0]   in_remote_receive,
  input  logic signed [63:0]   in_remote_send,
  input  logic [63:0]          in_local_receive,
  input  logic [63:0]          in_counter_now,
  input  logic                 cfg_valid,
  input  logic [0:0]           cfg_index,
  input  logic [63:0]          cfg_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [63:0]   out_utc_time,
  output logic [2:0]           out_status
);

  localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [IW:0] DepthV = (IW + 1)'(RING_DEPTH);
  localparam bit WinActive = WINDOW_MAX < RING_DEPTH;
  localparam logic [IW:0] WinV = WinActive ? (IW + 1)'(WINDOW_MAX) : '0;

  function automatic logic [IW-1:0] idx_next(input logic [IW-1:0] i);
    return (i == IW'(RING_DEPTH - 1)) ? '0 : i + IW'(1);
  endfunction

  function automatic logic [IW-1:0] idx_wrap(input logic [IW:0] s);
    logic [IW:0] r;
    r = (s >= DepthV) ? s - DepthV : s;
    return r[IW-1:0];
  endfunction

  // Latched input item.
  logic              req_r;
  logic [63:0]       lsend_r, lrecv_r, cnow_r;
  logic [63:0]       rrecv_r, rsend_r;

  // Configuration and estimator state.
  logic [4:0]        shift_r;
  logic [63:0]       iper_r;
  logic [IW-1:0]     wr_r, pidx_r, ref_r;
  logic [63:0]       coff_r, uoff_r, mper_r;
  logic              known_r;

  // Ring memory.
  logic [63:0]       mem_c [RING_DEPTH];
  logic [63:0]       mem_t [RING_DEPTH];
  logic [63:0]       rd_c_r, rd_t_r;

  logic [63:0]       cur_c_r, cur_t_r;
  logic [63:0]       dt_r, dc_r;
  logic              older_r;

  logic [63:0]       qc_r, per_r, prod_r, acc_r;
  logic [63:0]       res_time_r;
  cts_pkg::status_t  res_status_r;

  logic              out_valid_r;
  logic [63:0]       out_time_r;
  logic [2:0]        out_status_r;

  logic [63:0]       mid_c, mid_t, quot;
  logic              div_done;
  logic [IW-1:0]     wr_nxt, pnext, ref_win;
  logic [IW:0]       gap;
  logic              win_move;
  logic [31:0]       mul_a, mul_b;

  always_comb begin
    mid_c   = ((lsend_r >> 1) + (lrecv_r >> 1)) >> shift_r;
    mid_t   = 64'($signed(rsend_r) >>> 1) + 64'($signed(rrecv_r) >>> 1);
    wr_nxt  = idx_next(wr_r);
    pnext   = idx_next(pidx_r);
    gap     = {1'b0, idx_wrap({1'b0, pnext} + DepthV - {1'b0, ref_r})};
    win_move = WinActive && (gap > WinV);
    ref_win = idx_wrap({1'b0, pnext} + DepthV - WinV);
    unique case (cmd.mul_sel)
      cts_pkg::MUL_LL: begin mul_a = per_r[31:0];  mul_b = qc_r[31:0];  end
      cts_pkg::MUL_LH: begin mul_a = per_r[31:0];  mul_b = qc_r[63:32]; end
      cts_pkg::MUL_HL: begin mul_a = per_r[63:32]; mul_b = qc_r[31:0];  end
      default:         begin mul_a = per_r[31:0];  mul_b = qc_r[31:0];  end
    endcase
  end

  always_comb begin
    sts.is_query   = req_r == cts_pkg::REQ_QUERY;
    sts.ignore     = (rrecv_r == '0) || (rsend_r == '0) || (lsend_r > lrecv_r) ||
                     ($signed(rrecv_r) > $signed(rsend_r));
    sts.ref_is_cur = ref_r == pidx_r;
    sts.reject     = older_r || (dc_r[63:32] != '0) || (dt_r > cts_pkg::DtLimit) ||
                     (dc_r == '0);
    sts.div_done   = div_done;
    sts.out_free   = !out_valid_r || !out_stall;
  end

  cts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ({dt_r[41:0], 22'd0}),
    .divisor  (dc_r[31:0]),
    .done     (div_done),
    .quotient (quot)
  );

  // Control and estimator state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= '0;
      iper_r      <= cts_pkg::InitPeriodRst;
      wr_r        <= '0;
      pidx_r      <= '0;
      ref_r       <= '0;
      coff_r      <= '0;
      uoff_r      <= '0;
      mper_r      <= '0;
      known_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          cts_pkg::CFG_COUNTER_SHIFT:  shift_r <= cfg_data[4:0];
          cts_pkg::CFG_INITIAL_PERIOD: iper_r  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.ring_write) begin
        wr_r <= wr_nxt;
        if (wr_nxt == ref_r) begin
          ref_r <= idx_next(ref_r);
        end
      end
      if (cmd.sync_start || cmd.resync || cmd.period_fin) begin
        coff_r <= cur_c_r;
        uoff_r <= cur_t_r;
        pidx_r <= pnext;
      end
      if (cmd.resync) begin
        ref_r <= pidx_r;
      end
      if (cmd.period_fin) begin
        mper_r  <= quot;
        known_r <= 1'b1;
        if (win_move) begin
          ref_r <= ref_win;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req_r   <= in_req_type;
      lsend_r <= in_local_send;
      rrecv_r <= in_remote_receive;
      rsend_r <= in_remote_send;
      lrecv_r <= in_local_receive;
      cnow_r  <= in_counter_now;
    end
    if (cmd.ring_write) begin
      mem_c[wr_r] <= mid_c;
      mem_t[wr_r] <= mid_t;
      cur_c_r     <= mid_c;
      cur_t_r     <= mid_t;
    end
    if (cmd.ref_read) begin
      rd_c_r <= mem_c[ref_r];
      rd_t_r <= mem_t[ref_r];
    end
    if (cmd.cmp_load) begin
      older_r <= ($signed(rd_t_r) > $signed(cur_t_r)) || (rd_c_r > cur_c_r);
      dt_r    <= cur_t_r - rd_t_r;
      dc_r    <= cur_c_r - rd_c_r;
    end
    if (cmd.q_prep) begin
      qc_r  <= (cnow_r >> shift_r) - coff_r;
      per_r <= known_r ? mper_r : iper_r;
    end
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    unique case (cmd.acc_op)
      cts_pkg::ACC_LOAD:   acc_r <= prod_r;
      cts_pkg::ACC_ADD_HI: acc_r <= acc_r + {prod_r[31:0], 32'd0};
      default: ;
    endcase
    if (cmd.q_res) begin
      res_time_r <= 64'($signed(acc_r) >>> cts_pkg::PeriodShift) + uoff_r;
    end else if (cmd.res_set) begin
      res_time_r <= '0;
    end
    if (cmd.res_set) begin
      res_status_r <= cmd.status;
    end
    if (cmd.emit) begin
      out_time_r   <= res_time_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_utc_time = out_time_r;
  assign out_status   = out_status_r;

endmodule

// File: rtl/cts_ctrl.sv
// Controller state machine: sequences updates, queries and result transfer.
// Depends on cts_pkg.
`timescale 1ns / 1ps
module cts_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  cts_pkg::sts_t sts,
  output cts_pkg::cmd_t cmd
);

  cts_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cts_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_sel = cts_pkg::MUL_LL;
    cmd.acc_op  = cts_pkg::ACC_HOLD;
    cmd.status  = cts_pkg::ST_TIME;
    in_stall  = 1'b1;
    unique case (state_r)
      cts_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = cts_pkg::S_DECODE;
        end
      end
      cts_pkg::S_DECODE: begin
        if (sts.is_query) begin
          state_nxt = cts_pkg::S_QPREP;
        end else if (sts.ignore) begin
          cmd.res_set = 1'b1;
          cmd.status  = cts_pkg::ST_IGNORED;
          state_nxt   = cts_pkg::S_DONE;
        end else begin
          state_nxt = cts_pkg::S_WRITE;
        end
      end
      cts_pkg::S_WRITE: begin
        cmd.ring_write = 1'b1;
        state_nxt      = cts_pkg::S_READ;
      end
      cts_pkg::S_READ: begin
        if (sts.ref_is_cur) begin
          cmd.sync_start = 1'b1;
          cmd.res_set    = 1'b1;
          cmd.status     = cts_pkg::ST_SYNC;
          state_nxt      = cts_pkg::S_DONE;
        end else begin
          cmd.ref_read = 1'b1;
          state_nxt    = cts_pkg::S_CMP;
        end
      end
      cts_pkg::S_CMP: begin
        cmd.cmp_load = 1'b1;
        state_nxt    = cts_pkg::S_CHK;
      end
      cts_pkg::S_CHK: begin
        if (sts.reject) begin
          cmd.resync  = 1'b1;
          cmd.res_set = 1'b1;
          cmd.status  = cts_pkg::ST_RESYNC;
          state_nxt   = cts_pkg::S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = cts_pkg::S_DIV;
        end
      end
      cts_pkg::S_DIV: begin
        if (sts.div_done) begin
          state_nxt = cts_pkg::S_FIN;
        end
      end
      cts_pkg::S_FIN: begin
        cmd.period_fin = 1'b1;
        cmd.res_set    = 1'b1;
        cmd.status     = cts_pkg::ST_PERIOD;
        state_nxt      = cts_pkg::S_DONE;
      end
      cts_pkg::S_QPREP: begin
        cmd.q_prep = 1'b1;
        state_nxt  = cts_pkg::S_QM0;
      end
      cts_pkg::S_QM0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cts_pkg::MUL_LL;
        state_nxt   = cts_pkg::S_QM1;
      end
      cts_pkg::S_QM1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cts_pkg::MUL_LH;
        cmd.acc_op  = cts_pkg::ACC_LOAD;
        state_nxt   = cts_pkg::S_QM2;
      end
      cts_pkg::S_QM2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cts_pkg::MUL_HL;
        cmd.acc_op  = cts_pkg::ACC_ADD_HI;
        state_nxt   = cts_pkg::S_QM3;
      end
      cts_pkg::S_QM3: begin
        cmd.acc_op = cts_pkg::ACC_ADD_HI;
        state_nxt  = cts_pkg::S_QRES;
      end
      cts_pkg::S_QRES: begin
        cmd.q_res   = 1'b1;
        cmd.res_set = 1'b1;
        cmd.status  = cts_pkg::ST_TIME;
        state_nxt   = cts_pkg::S_DONE;
      end
      cts_pkg::S_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = cts_pkg::S_IDLE;
        end
      end
      default: state_nxt = cts_pkg::S_IDLE;
    endcase
  end

endmodule

// File: rtl/counter_to_utc_time_sync_top.sv
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_stall    req_type, stamps, counter_now
// out_      output     out_valid/out_stall  utc_time, status
// cfg_      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item at a time. A query passes through one shared 32x32 multiplier in the states
// QM0 to QM2, accumulating in QM1 to QM3, then QRES forms the result. An update that
// measures a period runs the 64-step restoring divider; a sync, a resync and an ignored
// update skip it. From S_DONE the controller returns to idle once the output is free.
// A finished result waits in the output register while the next item is taken.
// Reset is synchronous; the ring needs no clearing pass. cfg_ready is always high.
`timescale 1ns / 1ps
module counter_to_utc_time_sync_top #(
  parameter int RING_DEPTH = cts_pkg::RingDepthDef,
  parameter int WINDOW_MAX = cts_pkg::WindowMaxDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic [63:0]        in_local_send,
  input  logic signed [63:0] in_remote_receive,
  input  logic signed [63:0] in_remote_send,
  input  logic [63:0]        in_local_receive,
  input  logic [63:0]        in_counter_now,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_utc_time,
  output logic [2:0]         out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  cts_pkg::cmd_t cmd;
  cts_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  cts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  cts_dp #(
    .RING_DEPTH (RING_DEPTH),
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_req_type       (in_req_type),
    .in_local_send     (in_local_send),
    .in_remote_receive (in_remote_receive),
    .in_remote_send    (in_remote_send),
    .in_local_receive  (in_local_receive),
    .in_counter_now    (in_counter_now),
    .cfg_valid         (cfg_valid & cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_utc_time      (out_utc_time),
    .out_status        (out_status)
  );

endmodule
